// ===== rtl/d96add_pkg.sv =====
// Shared widths, types and constants for the 96-bit decimal adder.
package d96add_pkg;

  localparam int LIMB_W    = 32;
  localparam int NUM_LIMBS = 7;
  localparam int WIDE_W    = LIMB_W * NUM_LIMBS;
  localparam int MANT_W    = 96;
  localparam int SCALE_W   = 5;
  localparam int MAX_SCALE = 28;
  // The largest scale that can be presented, and so the most digits ever dropped.
  localparam int NUM_DIV   = 31;
  localparam int NUM_POW   = NUM_DIV + 1;
  localparam int DIGIT_W   = 4;

  typedef logic [WIDE_W-1:0]  wide_t;
  typedef logic [SCALE_W-1:0] scale_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_POS_OVF = 2'd1,
    STAT_NEG_OVF = 2'd2
  } status_t;

  // One item as it travels through the divide-by-ten stages.
  typedef struct packed {
    logic   valid;
    scale_t k;       // number of digits still to be dropped in total
    digit_t rem;     // running remainder inside one division
    digit_t dig;     // most significant dropped digit so far
    logic   sticky;  // any lower dropped digit was nonzero
    logic   neg;
    logic   ovf;
    scale_t scale;   // scale of the final result
    wide_t  val;
  } dtok_t;

  // Twice the sum must stay below (2^97 - 1) * 10^digits for the value rounded
  // to that many fewer digits to fit in the 96-bit magnitude.
  function automatic wide_t fit_limit(input int unsigned digits);
    wide_t v;
    v = wide_t'({(MANT_W + 1){1'b1}});
    for (int unsigned n = 0; n < digits; n++) begin
      v = (v << 3) + (v << 1);
    end
    return v;
  endfunction

endpackage

// ===== rtl/decimal96_add_bankers_round_top.sv =====
// Top level of the pipelined 96-bit decimal adder with round half to even.
//
//   Channel  Direction  Beat contents
//   s_axis   in         two operands: magnitude, scale and sign of each
//   m_axis   out        result magnitude, scale, sign and overflow status
//
// A beat is taken in every cycle in which the output side is not held up.
// Each result passes through 31 alignment stages and six more registers, and the
// division stage chain: 31 digits, each divided by ten one 32-bit limb per stage
// over seven limbs.
// Reset clears only the valid bits of the stages; data registers keep whatever they hold.
// When a finished beat waits on m_axis, every stage holds together, so no beat is
// lost or repeated, and s_axis_tready is low for that cycle.
module decimal96_add_bankers_round_top
  import d96add_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // From bit 0: a_mant_low(64), a_mant_high(32), a_scale(5), a_negative(1),
  // b_mant_low(64), b_mant_high(32), b_scale(5), b_negative(1), zero padding(4).
  input  logic [207:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // From bit 0: sum_mant_low(64), sum_mant_high(32), sum_scale(5),
  // sum_negative(1), status(2).
  output logic [103:0] m_axis_tdata
);

  localparam int OPND_W = MANT_W + SCALE_W + 1;
  localparam int KFIT_W = 6;

  // Operands on their way to a common scale; x is the one being scaled up.
  typedef struct packed {
    logic   valid;
    wide_t  x;
    wide_t  y;
    logic   xneg;
    logic   yneg;
    scale_t cnt;
    scale_t scale;
  } aln_t;

  logic adv;

  // The whole pipeline advances unless the output holds a beat not yet taken.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------------------------------------------------------------
  // Input capture: the operand with the smaller scale becomes x.
  // ---------------------------------------------------------------------
  logic [MANT_W-1:0] a_mant, b_mant;
  scale_t            a_scale, b_scale;
  logic              a_neg, b_neg;
  aln_t              aln [0:NUM_DIV];
  aln_t              aln_first;

  assign a_mant  = s_axis_tdata[MANT_W-1:0];
  assign a_scale = s_axis_tdata[MANT_W +: SCALE_W];
  assign a_neg   = s_axis_tdata[MANT_W + SCALE_W];
  assign b_mant  = s_axis_tdata[OPND_W +: MANT_W];
  assign b_scale = s_axis_tdata[OPND_W + MANT_W +: SCALE_W];
  assign b_neg   = s_axis_tdata[OPND_W + MANT_W + SCALE_W];

  always_comb begin
    aln_first.valid = s_axis_tvalid;
    if (a_scale < b_scale) begin
      aln_first.x     = WIDE_W'(a_mant);
      aln_first.xneg  = a_neg;
      aln_first.y     = WIDE_W'(b_mant);
      aln_first.yneg  = b_neg;
      aln_first.cnt   = b_scale - a_scale;
      aln_first.scale = b_scale;
    end else begin
      aln_first.x     = WIDE_W'(b_mant);
      aln_first.xneg  = b_neg;
      aln_first.y     = WIDE_W'(a_mant);
      aln_first.yneg  = a_neg;
      aln_first.cnt   = a_scale - b_scale;
      aln_first.scale = a_scale;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aln[0].valid <= 1'b0;
    end else if (adv) begin
      aln[0] <= aln_first;
    end
  end

  // ---------------------------------------------------------------------
  // Alignment: each stage multiplies x by ten while digits remain to be added.
  // ---------------------------------------------------------------------
  for (genvar s = 0; s < NUM_DIV; s++) begin : g_aln
    aln_t nxt;

    always_comb begin
      nxt = aln[s];
      if (aln[s].cnt != '0) begin
        nxt.x   = (aln[s].x << 3) + (aln[s].x << 1);
        nxt.cnt = aln[s].cnt - scale_t'(1);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        aln[s+1].valid <= 1'b0;
      end else if (adv) begin
        aln[s+1] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Add or subtract. A borrow out of x - y means y was the larger magnitude.
  // ---------------------------------------------------------------------
  aln_t            last_aln;
  logic            as_valid;
  logic [WIDE_W:0] as_diff;
  logic            as_same;
  logic            as_xneg;
  logic            as_yneg;
  scale_t          as_scale;

  assign last_aln = aln[NUM_DIV];

  always_ff @(posedge clk) begin
    if (rst) begin
      as_valid <= 1'b0;
    end else if (adv) begin
      as_valid <= last_aln.valid;
    end
    if (adv) begin
      as_same  <= (last_aln.xneg == last_aln.yneg);
      as_xneg  <= last_aln.xneg;
      as_yneg  <= last_aln.yneg;
      as_scale <= last_aln.scale;
      if (last_aln.xneg == last_aln.yneg) begin
        as_diff <= {1'b0, last_aln.x} + {1'b0, last_aln.y};
      end else begin
        as_diff <= {1'b0, last_aln.x} - {1'b0, last_aln.y};
      end
    end
  end

  // ---------------------------------------------------------------------
  // Take the magnitude and settle the sign; equal magnitudes of opposite sign give +0.
  // ---------------------------------------------------------------------
  logic   nm_valid;
  wide_t  nm_sum;
  logic   nm_neg;
  scale_t nm_scale;
  logic   as_borrow;

  assign as_borrow = !as_same && as_diff[WIDE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid <= 1'b0;
    end else if (adv) begin
      nm_valid <= as_valid;
    end
    if (adv) begin
      nm_scale <= as_scale;
      if (as_borrow) begin
        nm_sum <= wide_t'(~as_diff[WIDE_W-1:0]) + wide_t'(1);
        nm_neg <= as_yneg;
      end else begin
        nm_sum <= as_diff[WIDE_W-1:0];
        if (as_same) begin
          nm_neg <= as_xneg;
        end else begin
          nm_neg <= (as_diff[WIDE_W-1:0] != '0) && as_xneg;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Fit test: for every digit count, whether the sum rounded to that many
  // fewer digits fits in 96 bits. The tests are independent of each other.
  // ---------------------------------------------------------------------
  wide_t              sum_x2;
  logic [NUM_POW-1:0] lt_next;
  logic [NUM_POW-1:0] cp_lt;
  logic               cp_valid;
  wide_t              cp_sum;
  logic               cp_neg;
  scale_t             cp_scale;

  assign sum_x2 = {nm_sum[WIDE_W-2:0], 1'b0};

  for (genvar i = 0; i < NUM_POW; i++) begin : g_fit
    assign lt_next[i] = (sum_x2 < fit_limit(i));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cp_valid <= 1'b0;
    end else if (adv) begin
      cp_valid <= nm_valid;
    end
    if (adv) begin
      cp_lt    <= lt_next;
      cp_sum   <= nm_sum;
      cp_neg   <= nm_neg;
      cp_scale <= nm_scale;
    end
  end

  // ---------------------------------------------------------------------
  // Digit count: at least enough to reach scale 28, at least enough to fit,
  // never more than the scale. If even that does not fit, it is an overflow.
  // ---------------------------------------------------------------------
  logic [KFIT_W-1:0] kfit;
  logic [KFIT_W-1:0] k_low;
  logic [KFIT_W-1:0] k_need;
  logic              k_ovf;
  scale_t            k_final;
  dtok_t             dv_in;
  dtok_t             dv_out;

  always_comb begin
    kfit = KFIT_W'(NUM_POW);
    for (int i = NUM_POW - 1; i >= 0; i--) begin
      if (cp_lt[i]) begin
        kfit = KFIT_W'(i);
      end
    end
    if (cp_scale > scale_t'(MAX_SCALE)) begin
      k_low = KFIT_W'(cp_scale - scale_t'(MAX_SCALE));
    end else begin
      k_low = '0;
    end
    k_need  = (kfit > k_low) ? kfit : k_low;
    k_ovf   = kfit > KFIT_W'(cp_scale);
    k_final = k_ovf ? cp_scale : k_need[SCALE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_in.valid <= 1'b0;
    end else if (adv) begin
      dv_in.valid <= cp_valid;
    end
    if (adv) begin
      dv_in.k      <= k_final;
      dv_in.rem    <= '0;
      dv_in.dig    <= '0;
      dv_in.sticky <= 1'b0;
      dv_in.neg    <= cp_neg;
      dv_in.ovf    <= k_ovf;
      dv_in.scale  <= cp_scale - k_final;
      dv_in.val    <= cp_sum;
    end
  end

  d96add_div10 u_div10 (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .tok_in  (dv_in),
    .tok_out (dv_out)
  );

  // ---------------------------------------------------------------------
  // Round half to even on the dropped digits, then the output register.
  // ---------------------------------------------------------------------
  logic              round_up;
  logic [MANT_W-1:0] rounded;
  logic [MANT_W-1:0] out_mant;
  scale_t            out_scale;
  logic              out_neg;
  status_t           out_status;
  logic              out_valid;

  assign round_up = (dv_out.dig > digit_t'(5)) ||
                    ((dv_out.dig == digit_t'(5)) && (dv_out.sticky || dv_out.val[0]));
  assign rounded  = dv_out.val[MANT_W-1:0] + MANT_W'(round_up);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_out.valid;
    end
    if (adv) begin
      if (dv_out.ovf) begin
        out_mant   <= '0;
        out_scale  <= '0;
        out_neg    <= 1'b0;
        out_status <= dv_out.neg ? STAT_NEG_OVF : STAT_POS_OVF;
      end else begin
        out_mant   <= rounded;
        out_scale  <= dv_out.scale;
        out_neg    <= dv_out.neg;
        out_status <= STAT_OK;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_status, out_neg, out_scale, out_mant};

  // ---------------------------------------------------------------------
  // Checks on the internal arithmetic.
  // ---------------------------------------------------------------------
  a_aligned : assert property (@(posedge clk) disable iff (rst)
    last_aln.valid |-> (last_aln.cnt == '0))
    else $error("alignment count not exhausted at the end of the alignment stages");

  a_scale_range : assert property (@(posedge clk) disable iff (rst)
    (dv_in.valid && !dv_in.ovf) |-> (dv_in.scale <= scale_t'(MAX_SCALE)))
    else $error("chosen digit count leaves a scale above the maximum");

  a_quot_fits : assert property (@(posedge clk) disable iff (rst)
    (dv_out.valid && !dv_out.ovf) |-> (dv_out.val[WIDE_W-1:MANT_W] == '0))
    else $error("quotient after division does not fit the magnitude");

  a_round_fits : assert property (@(posedge clk) disable iff (rst)
    (dv_out.valid && !dv_out.ovf && round_up) |-> (dv_out.val[MANT_W-1:0] != '1))
    else $error("rounding carries out of the magnitude");

endmodule

// ===== rtl/d96add_div10.sv =====
// Pipelined long division by ten, one 32-bit limb per stage, repeated per digit.
module d96add_div10
  import d96add_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  dtok_t tok_in,
  output dtok_t tok_out
);

  localparam int NUM_STG = NUM_DIV * NUM_LIMBS;
  localparam int CUR_W   = DIGIT_W + LIMB_W;
  localparam int PROD_W  = 2 * CUR_W;
  // ceil(2^39 / 10); exact for every dividend below 2^38.
  localparam logic [CUR_W-1:0] RECIP = 36'hCCCCCCCCD;
  localparam int RECIP_SH = 39;

  dtok_t pipe [1:NUM_STG];

  for (genvar s = 0; s < NUM_STG; s++) begin : g_stg
    localparam int DIV_IDX = s / NUM_LIMBS;
    localparam int LIMB    = NUM_LIMBS - 1 - (s % NUM_LIMBS);

    dtok_t              stg_in;
    dtok_t              nxt;
    digit_t             rem_in;
    logic [CUR_W-1:0]   cur;
    logic [PROD_W-1:0]  prod;
    logic [LIMB_W-1:0]  quo;
    logic [CUR_W-1:0]   back;
    digit_t             rem_out;

    if (s == 0) begin : g_head
      assign stg_in = tok_in;
    end else begin : g_body
      assign stg_in = pipe[s];
    end

    always_comb begin
      nxt     = stg_in;
      rem_in  = (LIMB == NUM_LIMBS - 1) ? '0 : stg_in.rem;
      cur     = {rem_in, stg_in.val[LIMB*LIMB_W +: LIMB_W]};
      prod    = PROD_W'(cur) * PROD_W'(RECIP);
      quo     = prod[RECIP_SH +: LIMB_W];
      back    = cur - ((CUR_W'(quo) << 3) + (CUR_W'(quo) << 1));
      rem_out = back[DIGIT_W-1:0];
      if (stg_in.k > scale_t'(DIV_IDX)) begin
        nxt.val[LIMB*LIMB_W +: LIMB_W] = quo;
        nxt.rem = rem_out;
        if (LIMB == 0) begin
          nxt.sticky = stg_in.sticky | (stg_in.dig != '0);
          nxt.dig    = rem_out;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[s+1].valid <= 1'b0;
      end else if (adv) begin
        pipe[s+1] <= nxt;
      end
    end
  end

  assign tok_out = pipe[NUM_STG];

endmodule

// ===== bench/decimal96_add_bankers_round_top_tb.sv =====
// Self-checking testbench for the pipelined 96-bit decimal adder with round half to even.
`timescale 1ns / 1ps

module decimal96_add_bankers_round_top_tb
  import d96add_pkg::*;
();

  typedef logic [255:0] exact_t;

  // One row of the directed stimulus table. A typed-in sum is used only where the
  // answer is obvious; all other rows are checked against the predictor.
  typedef struct {
    logic [207:0] operands;
    bit           typed;
    logic [103:0] sum;
  } vector_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;

  logic [103:0] pending_sums[$];
  vector_t      vectors[$];
  int           mismatches;
  int           send_idle;
  int           recv_stall;
  bit           hold_request;

  decimal96_add_bankers_round_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 2 ns clock period.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [207:0] pack_operands(
    logic [95:0] a_mag, logic [4:0] a_scl, logic a_neg,
    logic [95:0] b_mag, logic [4:0] b_scl, logic b_neg);
    return {4'b0, b_neg, b_scl, b_mag, a_neg, a_scl, a_mag};
  endfunction

  function automatic logic [103:0] pack_sum(
    status_t st, logic neg, logic [4:0] scl, logic [95:0] mag);
    return {st, neg, scl, mag};
  endfunction

  // Exact decimal sum: align the scales, add or subtract at full width, then drop
  // digits one at a time, rounding half to even from the exact value each time.
  function automatic logic [103:0] decimal_sum(logic [207:0] ops);
    exact_t     a_mag;
    exact_t     b_mag;
    exact_t     total;
    exact_t     trunc;
    exact_t     rounded;
    int         a_scl;
    int         b_scl;
    int         scl;
    logic       a_neg;
    logic       b_neg;
    logic       neg;
    int         dig;
    bit         sticky;
    bit         fits;
    a_mag  = exact_t'(ops[95:0]);
    a_scl  = int'(ops[100:96]);
    a_neg  = ops[101];
    b_mag  = exact_t'(ops[197:102]);
    b_scl  = int'(ops[202:198]);
    b_neg  = ops[203];
    dig    = 0;
    sticky = 0;
    scl    = a_scl;
    while (scl < b_scl) begin
      a_mag = a_mag * 10;
      scl++;
    end
    while (b_scl < scl) begin
      b_mag = b_mag * 10;
      b_scl++;
    end
    if (a_neg == b_neg) begin
      total = a_mag + b_mag;
      neg   = a_neg;
    end else if (a_mag > b_mag) begin
      total = a_mag - b_mag;
      neg   = a_neg;
    end else if (a_mag < b_mag) begin
      total = b_mag - a_mag;
      neg   = b_neg;
    end else begin
      total = '0;
      neg   = 1'b0;
    end
    trunc = total;
    while (1) begin
      rounded = trunc;
      if (dig > 5 || (dig == 5 && (sticky || trunc[0]))) begin
        rounded = trunc + 1;
      end
      fits = (rounded[255:96] == '0);
      if (scl <= MAX_SCALE && fits) break;
      if (scl == 0) break;
      if (dig != 0) sticky = 1;
      dig   = int'(trunc % 10);
      trunc = trunc / 10;
      scl--;
    end
    if (!fits) begin
      return pack_sum(neg ? STAT_NEG_OVF : STAT_POS_OVF, 1'b0, 5'd0, 96'd0);
    end
    return pack_sum(STAT_OK, neg, scl[4:0], rounded[95:0]);
  endfunction

  function automatic logic [95:0] random_magnitude();
    case ($urandom_range(5))
      0: return 96'($urandom_range(1000));
      1: return '1;
      2: return '1 - 96'($urandom_range(20));
      3: return '0;
      default: return {$urandom, $urandom, $urandom};
    endcase
  endfunction

  function automatic logic [4:0] random_scale();
    if ($urandom_range(9) == 0) return 5'($urandom_range(31, 29));
    return 5'($urandom_range(MAX_SCALE));
  endfunction

  function automatic logic [207:0] random_operands();
    logic [95:0] a_mag;
    logic [4:0]  a_scl;
    logic        a_neg;
    a_mag = random_magnitude();
    a_scl = random_scale();
    a_neg = 1'($urandom);
    // Now and then the second operand mirrors the first, so cancellation to zero
    // and exact doubling both turn up often enough.
    if ($urandom_range(7) == 0) begin
      return pack_operands(a_mag, a_scl, a_neg, a_mag, a_scl, 1'($urandom));
    end
    return pack_operands(a_mag, a_scl, a_neg, random_magnitude(), random_scale(),
                         1'($urandom));
  endfunction

  task automatic note_mismatch(string field, logic [95:0] got, logic [95:0] want);
    $display("mismatch in %s: got %h, expected %h", field, got, want);
    mismatches++;
  endtask

  // Offers one beat, idling first as the current phase asks. Starts and ends at a
  // falling edge, so the valid line is never written twice in one time step.
  task automatic offer_beat(logic [207:0] ops, bit typed, logic [103:0] typed_sum);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ops;
    do @(posedge clk); while (!s_axis_tready);
    pending_sums.push_back(typed ? typed_sum : decimal_sum(ops));
    @(negedge clk);
  endtask

  task automatic add_vector(logic [207:0] ops, bit typed, logic [103:0] sum);
    vector_t v;
    v.operands = ops;
    v.typed    = typed;
    v.sum      = sum;
    vectors.push_back(v);
  endtask

  // Receiver side: random stalls, plus one long hold-off on request so that the
  // pipeline fills completely and back-pressure reaches the input.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (700) begin
          m_axis_tready <= 1'b0;
          @(negedge clk);
        end
      end else if (!rst) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // Result beats are compared field by field with the oldest expected sum.
  always @(posedge clk) begin
    logic [103:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_sums.size() == 0) begin
        note_mismatch("unexpected beat", m_axis_tdata[95:0], 96'd0);
      end else begin
        want = pending_sums.pop_front();
        if (m_axis_tdata[63:0] !== want[63:0])
          note_mismatch("sum_mant_low", m_axis_tdata[63:0], want[63:0]);
        if (m_axis_tdata[95:64] !== want[95:64])
          note_mismatch("sum_mant_high", m_axis_tdata[95:64], want[95:64]);
        if (m_axis_tdata[100:96] !== want[100:96])
          note_mismatch("sum_scale", m_axis_tdata[100:96], want[100:96]);
        if (m_axis_tdata[101] !== want[101])
          note_mismatch("sum_negative", m_axis_tdata[101], want[101]);
        if (m_axis_tdata[103:102] !== want[103:102])
          note_mismatch("status", m_axis_tdata[103:102], want[103:102]);
      end
    end
  end

  // Watchdog for a hung pipeline.
  initial begin
    #1_500_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [95:0] top;
    int          rows;
    top           = '1;
    mismatches    = 0;
    send_idle     = 0;
    recv_stall    = 0;
    hold_request  = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;

    // Zero plus zero, both signs of zero, largest magnitudes with overflow of
    // either sign, and exact cancellation.
    add_vector(pack_operands(0, 0, 0, 0, 0, 0), 1, pack_sum(STAT_OK, 0, 0, 0));
    add_vector(pack_operands(0, 0, 1, 0, 0, 1), 1, pack_sum(STAT_OK, 1, 0, 0));
    add_vector(pack_operands(0, 5, 1, 0, 0, 0), 1, pack_sum(STAT_OK, 0, 5, 0));
    add_vector(pack_operands(top, 0, 0, top, 0, 0), 1, pack_sum(STAT_POS_OVF, 0, 0, 0));
    add_vector(pack_operands(top, 0, 1, top, 0, 1), 1, pack_sum(STAT_NEG_OVF, 0, 0, 0));
    add_vector(pack_operands(top, 0, 0, top, 0, 1), 1, pack_sum(STAT_OK, 0, 0, 0));
    add_vector(pack_operands(top, 28, 0, 0, 0, 1), 1, pack_sum(STAT_OK, 0, 28, top));
    // Scale alignment across the whole range, and scales past the largest legal one.
    add_vector(pack_operands(1, 0, 0, 1, 28, 0), 0, '0);
    add_vector(pack_operands(top, 28, 1, top, 28, 1), 0, '0);
    add_vector(pack_operands(top, 0, 0, 1, 28, 1), 0, '0);
    add_vector(pack_operands(top, 31, 0, 7, 29, 1), 0, '0);
    add_vector(pack_operands(5, 31, 1, 0, 31, 1), 0, '0);
    add_vector(pack_operands(top, 30, 1, top, 31, 0), 0, '0);
    // Rounding of a dropped half digit towards even, and a rounding carry.
    add_vector(pack_operands(top, 1, 0, 1, 1, 0), 0, '0);
    add_vector(pack_operands(top - 1, 1, 0, 1, 1, 0), 0, '0);
    add_vector(pack_operands(top, 1, 0, 5, 1, 0), 0, '0);
    add_vector(pack_operands(top, 2, 0, 50, 2, 0), 0, '0);
    add_vector(pack_operands(top, 2, 0, 51, 2, 0), 0, '0);
    // Differing signs where the smaller magnitude is the first operand.
    add_vector(pack_operands(3, 2, 0, 1, 0, 1), 0, '0);
    add_vector(pack_operands(96'h1, 0, 1, top, 0, 0), 0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    rows = vectors.size();
    for (int i = 0; i < rows; i++) begin
      offer_beat(vectors[i].operands, vectors[i].typed, vectors[i].sum);
    end

    // Random phases: no idling (with one long receiver hold-off), idle sender,
    // stalling receiver, then both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  hold_request = 1'b1; end
        1: begin send_idle = 61; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 61; end
        default: begin send_idle = 25; recv_stall = 25; end
      endcase
      repeat (190) offer_beat(random_operands(), 0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_sums.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
